// ----- sv/pps_pkg.sv -----
package pps_pkg;

   localparam int MAX_PROCS = 16;
   localparam int IDX_W     = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
   localparam int CNT_W     = $clog2(MAX_PROCS + 1);

   localparam int TIME_W = 16;
   localparam int PRIO_W = 8;
   localparam int TICK_W = 21;
   localparam int PNUM_W = 5;
   localparam int TOT_W  = 25;

   localparam int REQ_DATA_W = 2 * TIME_W + PRIO_W + 0;
   localparam int RSP_USED_W = PNUM_W + 3 * TICK_W + 2 * TOT_W;
   localparam int RSP_DATA_W = ((RSP_USED_W + 7) / 8) * 8;
   localparam int RSP_PAD_W  = RSP_DATA_W - RSP_USED_W;

   // one stored process
   typedef struct packed {
      logic [TIME_W-1:0] arrival;
      logic [TIME_W-1:0] burst;
      logic [PRIO_W-1:0] priority_val;
      logic [TIME_W-1:0] remaining;
      logic [TICK_W-1:0] completion;
   } proc_rec_type;

   typedef struct packed {
      logic clear;
      logic eval;
   } scan_ctl_type;

   typedef struct packed {
      logic              found;
      logic [IDX_W-1:0]  best_idx;
      proc_rec_type      best_rec;
      logic              has_next;
      logic [TIME_W-1:0] next_arr;
   } scan_result_type;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_SCAN,
      ST_GAP,
      ST_RUN,
      ST_COMMIT,
      ST_OUT_RD,
      ST_OUT_TAT,
      ST_OUT_WT,
      ST_OUT_SUM,
      ST_OUT_SEND
   } state_type;

endpackage

// ----- sv/pps_scan.sv -----
module pps_scan
   import pps_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  scan_ctl_type      ctl,
   input  proc_rec_type      rec,
   input  logic [TICK_W-1:0] tick,
   output scan_result_type   res
);

   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              found_ff, found_in;
   logic [IDX_W-1:0]  best_idx_ff, best_idx_in;
   proc_rec_type      best_rec_ff, best_rec_in;
   logic              has_next_ff, has_next_in;
   logic [TIME_W-1:0] next_arr_ff, next_arr_in;

   logic              live, ready, later, take, next_take;
   logic [TICK_W-1:0] arr_ext;

   always_comb begin
      arr_ext   = TICK_W'(rec.arrival);
      live      = (rec.remaining != '0);
      ready     = live && (arr_ext <= tick);
      later     = live && (arr_ext > tick);
      take      = ready && (!found_ff || (rec.priority_val < best_rec_ff.priority_val));
      next_take = later && (!has_next_ff || (rec.arrival < next_arr_ff));

      idx_in      = idx_ff;
      found_in    = found_ff;
      best_idx_in = best_idx_ff;
      best_rec_in = best_rec_ff;
      has_next_in = has_next_ff;
      next_arr_in = next_arr_ff;
      if (ctl.clear) begin
         idx_in      = '0;
         found_in    = 1'b0;
         has_next_in = 1'b0;
      end else if (ctl.eval) begin
         idx_in = idx_ff + 1'b1;
         // strict compare keeps the lower index on a tie
         if (take) begin
            found_in    = 1'b1;
            best_idx_in = idx_ff;
            best_rec_in = rec;
         end
         if (next_take) begin
            has_next_in = 1'b1;
            next_arr_in = rec.arrival;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff      <= '0;
         found_ff    <= 1'b0;
         has_next_ff <= 1'b0;
      end else begin
         idx_ff      <= idx_in;
         found_ff    <= found_in;
         has_next_ff <= has_next_in;
      end
   end

   always_ff @(posedge clock) begin
      best_idx_ff <= best_idx_in;
      best_rec_ff <= best_rec_in;
      next_arr_ff <= next_arr_in;
   end

   assign res.found    = found_ff;
   assign res.best_idx = best_idx_ff;
   assign res.best_rec = best_rec_ff;
   assign res.has_next = has_next_ff;
   assign res.next_arr = next_arr_ff;

endmodule

// ----- sv/preemptive_priority_scheduler_top.sv -----
// preemptive priority scheduler: processes are loaded one beat per cycle (arrival, burst,
// priority); a beat with tlast starts a preemptive priority schedule from tick 0 over the
// stored processes, smallest priority value first and the lower index on a tie, then one
// result beat per process goes out in load order with running totals and tlast on the final
// one. beats past the capacity are dropped but their tlast still starts the schedule; a burst
// of zero counts as one. all process records sit in one memory with a registered read, so the
// schedule advances event by event instead of tick by tick: a decision scans the records,
// then runs the chosen process in the gap, run and commit states up to its completion or the
// next arrival, whichever comes first, and writes it back. there are at most about twice the
// process count decisions. each result passes the read, tat, wt, sum and send states, waiting
// in send on a stall. no new process is taken while a batch is scheduled or reported.
module preemptive_priority_scheduler_top
   import pps_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_tvalid,
   output logic                  req_tready,
   // arrival_time[15:0], burst_time[31:16], priority_req[39:32]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // last_process
   input  logic                  req_tlast,

   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // process_number[4:0], completion_time[25:5], turnaround_time[46:26],
   // waiting_time[67:47], total_turnaround[92:68], total_waiting[117:93], zero pad
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // last_result
   output logic                  rsp_tlast
);

   // process record memory
   proc_rec_type     mem [MAX_PROCS];
   proc_rec_type     rd_data_ff;
   logic             rd_en, wr_en;
   logic [IDX_W-1:0] rd_addr, wr_addr;
   proc_rec_type     wr_data;

   state_type state_ff, state_in;

   // control state
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  finished_ff, finished_in;
   logic [TICK_W-1:0] tick_ff, tick_in;
   logic [CNT_W-1:0]  scan_idx_ff, scan_idx_in;
   logic              eval_vld_ff, eval_vld_in;
   logic [CNT_W-1:0]  out_idx_ff, out_idx_in;
   logic              rsp_vld_ff, rsp_vld_in;

   // datapath
   logic [TICK_W-1:0] gap_ff, gap_in;
   logic [TIME_W-1:0] run_ff, run_in;
   logic              done_ff, done_in;
   logic [TICK_W-1:0] tat_ff, tat_in;
   logic [TICK_W-1:0] wt_ff, wt_in;
   logic [TOT_W-1:0]  sum_tat_ff, sum_tat_in;
   logic [TOT_W-1:0]  sum_wt_ff, sum_wt_in;

   // result register
   logic [PNUM_W-1:0] o_pnum_ff, o_pnum_in;
   logic [TICK_W-1:0] o_ct_ff, o_ct_in;
   logic [TICK_W-1:0] o_tat_ff, o_tat_in;
   logic [TICK_W-1:0] o_wt_ff, o_wt_in;
   logic [TOT_W-1:0]  o_stat_ff, o_stat_in;
   logic [TOT_W-1:0]  o_swt_ff, o_swt_in;
   logic              o_last_ff, o_last_in;

   scan_ctl_type    scan_ctl;
   scan_result_type scan_res;

   logic [TIME_W-1:0] req_arrival, req_burst, burst_fix;
   logic [PRIO_W-1:0] req_prio;
   logic [TICK_W-1:0] tick_run;
   proc_rec_type      commit_rec;

   assign req_arrival = req_tdata[TIME_W-1:0];
   assign req_burst   = req_tdata[2*TIME_W-1:TIME_W];
   assign req_prio    = req_tdata[2*TIME_W+PRIO_W-1:2*TIME_W];
   // a zero burst is served as one tick
   assign burst_fix   = (req_burst == '0) ? TIME_W'(1) : req_burst;

   assign tick_run = tick_ff + TICK_W'(run_ff);

   pps_scan u_scan (
      .clock (clock),
      .reset (reset),
      .ctl   (scan_ctl),
      .rec   (rd_data_ff),
      .tick  (tick_ff),
      .res   (scan_res)
   );

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      finished_in = finished_ff;
      tick_in     = tick_ff;
      scan_idx_in = scan_idx_ff;
      eval_vld_in = 1'b0;
      out_idx_in  = out_idx_ff;
      rsp_vld_in  = rsp_vld_ff;
      gap_in      = gap_ff;
      run_in      = run_ff;
      done_in     = done_ff;
      tat_in      = tat_ff;
      wt_in       = wt_ff;
      sum_tat_in  = sum_tat_ff;
      sum_wt_in   = sum_wt_ff;
      o_pnum_in   = o_pnum_ff;
      o_ct_in     = o_ct_ff;
      o_tat_in    = o_tat_ff;
      o_wt_in     = o_wt_ff;
      o_stat_in   = o_stat_ff;
      o_swt_in    = o_swt_ff;
      o_last_in   = o_last_ff;

      rd_en          = 1'b0;
      rd_addr        = '0;
      wr_en          = 1'b0;
      wr_addr        = '0;
      wr_data        = '0;
      req_tready     = 1'b0;
      scan_ctl.clear = 1'b0;
      scan_ctl.eval  = eval_vld_ff;

      commit_rec           = scan_res.best_rec;
      commit_rec.remaining = scan_res.best_rec.remaining - run_ff;
      if (done_ff) begin
         commit_rec.completion = tick_run;
      end

      unique case (state_ff)
         ST_LOAD: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (count_ff < CNT_W'(MAX_PROCS)) begin
                  wr_en                = 1'b1;
                  wr_addr              = count_ff[IDX_W-1:0];
                  wr_data.arrival      = req_arrival;
                  wr_data.burst        = burst_fix;
                  wr_data.priority_val = req_prio;
                  wr_data.remaining    = burst_fix;
                  wr_data.completion   = '0;
                  count_in             = count_ff + 1'b1;
               end
               if (req_tlast) begin
                  tick_in        = '0;
                  finished_in    = '0;
                  scan_idx_in    = '0;
                  scan_ctl.clear = 1'b1;
                  state_in       = ST_SCAN;
               end
            end
         end

         ST_SCAN: begin
            // one read per cycle, the scanner sees the data in the next cycle
            if (scan_idx_ff < count_ff) begin
               rd_en       = 1'b1;
               rd_addr     = scan_idx_ff[IDX_W-1:0];
               scan_idx_in = scan_idx_ff + 1'b1;
               eval_vld_in = 1'b1;
            end else if (!eval_vld_ff) begin
               state_in = ST_GAP;
            end
         end

         ST_GAP: begin
            // ticks until the next arrival among unfinished processes
            gap_in   = TICK_W'(scan_res.next_arr) - tick_ff;
            state_in = ST_RUN;
         end

         ST_RUN: begin
            // run to completion unless a new arrival may preempt first
            if (scan_res.has_next &&
                (gap_ff < TICK_W'(scan_res.best_rec.remaining))) begin
               run_in  = gap_ff[TIME_W-1:0];
               done_in = 1'b0;
            end else begin
               run_in  = scan_res.best_rec.remaining;
               done_in = 1'b1;
            end
            state_in = ST_COMMIT;
         end

         ST_COMMIT: begin
            scan_idx_in = '0;
            if (scan_res.found) begin
               wr_en   = 1'b1;
               wr_addr = scan_res.best_idx;
               wr_data = commit_rec;
               tick_in = tick_run;
               if (done_ff) begin
                  finished_in = finished_ff + 1'b1;
               end
            end else begin
               // idle: jump to the next arrival
               tick_in = TICK_W'(scan_res.next_arr);
            end
            if (scan_res.found && done_ff && (finished_ff + 1'b1 == count_ff)) begin
               out_idx_in = '0;
               sum_tat_in = '0;
               sum_wt_in  = '0;
               state_in   = ST_OUT_RD;
            end else begin
               scan_ctl.clear = 1'b1;
               state_in       = ST_SCAN;
            end
         end

         ST_OUT_RD: begin
            rd_en    = 1'b1;
            rd_addr  = out_idx_ff[IDX_W-1:0];
            state_in = ST_OUT_TAT;
         end

         ST_OUT_TAT: begin
            tat_in   = rd_data_ff.completion - TICK_W'(rd_data_ff.arrival);
            state_in = ST_OUT_WT;
         end

         ST_OUT_WT: begin
            wt_in      = tat_ff - TICK_W'(rd_data_ff.burst);
            sum_tat_in = sum_tat_ff + TOT_W'(tat_ff);
            state_in   = ST_OUT_SUM;
         end

         ST_OUT_SUM: begin
            sum_wt_in  = sum_wt_ff + TOT_W'(wt_ff);
            o_pnum_in  = PNUM_W'(out_idx_ff + 1'b1);
            o_ct_in    = rd_data_ff.completion;
            o_tat_in   = tat_ff;
            o_wt_in    = wt_ff;
            o_stat_in  = sum_tat_ff;
            o_swt_in   = sum_wt_ff + TOT_W'(wt_ff);
            o_last_in  = (out_idx_ff + 1'b1 == count_ff);
            rsp_vld_in = 1'b1;
            state_in   = ST_OUT_SEND;
         end

         ST_OUT_SEND: begin
            if (rsp_tready) begin
               rsp_vld_in = 1'b0;
               if (o_last_ff) begin
                  count_in    = '0;
                  tick_in     = '0;
                  finished_in = '0;
                  state_in    = ST_LOAD;
               end else begin
                  out_idx_in = out_idx_ff + 1'b1;
                  state_in   = ST_OUT_RD;
               end
            end
         end

         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_LOAD;
         count_ff    <= '0;
         finished_ff <= '0;
         tick_ff     <= '0;
         scan_idx_ff <= '0;
         eval_vld_ff <= 1'b0;
         out_idx_ff  <= '0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         finished_ff <= finished_in;
         tick_ff     <= tick_in;
         scan_idx_ff <= scan_idx_in;
         eval_vld_ff <= eval_vld_in;
         out_idx_ff  <= out_idx_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      gap_ff     <= gap_in;
      run_ff     <= run_in;
      done_ff    <= done_in;
      tat_ff     <= tat_in;
      wt_ff      <= wt_in;
      sum_tat_ff <= sum_tat_in;
      sum_wt_ff  <= sum_wt_in;
      o_pnum_ff  <= o_pnum_in;
      o_ct_ff    <= o_ct_in;
      o_tat_ff   <= o_tat_in;
      o_wt_ff    <= o_wt_in;
      o_stat_ff  <= o_stat_in;
      o_swt_ff   <= o_swt_in;
      o_last_ff  <= o_last_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tlast  = o_last_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, o_swt_ff, o_stat_ff, o_wt_ff, o_tat_ff,
                        o_ct_ff, o_pnum_ff};

endmodule

// ----- sv/pps_checker.sv -----
module pps_checker
   import pps_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [REQ_DATA_W-1:0] req_tdata,
   input logic                  req_tlast,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tlast
);

   logic [TICK_W-1:0] ct, tat, wt;
   logic [TOT_W-1:0]  stat;

   assign ct   = rsp_tdata[PNUM_W+TICK_W-1:PNUM_W];
   assign tat  = rsp_tdata[PNUM_W+2*TICK_W-1:PNUM_W+TICK_W];
   assign wt   = rsp_tdata[PNUM_W+3*TICK_W-1:PNUM_W+2*TICK_W];
   assign stat = rsp_tdata[PNUM_W+3*TICK_W+TOT_W-1:PNUM_W+3*TICK_W];

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result beat changed while stalled");

   // no loading while a batch is being reported
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("load side open while results pending");

   // times are ordered: completion >= turnaround >= waiting, totals cover the current one
   a_time_order: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (ct >= tat) && (tat >= wt) && (stat >= TOT_W'(tat)))
      else $error("inconsistent result times");

   // the block comes out of reset ready to load
   a_reset_ready: assert property (@(posedge clock)
      reset |=> req_tready && !rsp_tvalid)
      else $error("not ready after reset");

endmodule

bind preemptive_priority_scheduler_top pps_checker u_pps_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
